### src/mcc_pkg.sv
package mcc_pkg;

  localparam int MAX_BASE   = 8;
  localparam int MAX_LEVELS = 8;
  localparam int FRAC_BITS  = 16;

  // fixed field widths
  localparam int OP_W    = 1;
  localparam int WIDX_W  = 6;
  localparam int WVAL_W  = 17;
  localparam int COORD_W = 24;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam int TABLE_DEPTH = MAX_BASE * MAX_BASE;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int DIG_W       = $clog2(MAX_BASE);
  localparam int CB_W        = $clog2(MAX_BASE + 1);
  localparam int SLOT_W      = DIG_W + CB_W;
  localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
  localparam int VAL_W       = FRAC_BITS + 1;

  // q = (v * ceil(2^S / b)) >> S is exact for v < 2^COORD_W, b <= 2^DIG_W
  localparam int RECIP_SHIFT = COORD_W + DIG_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd2;

  typedef struct packed {
    logic                 operation;
    logic [WIDX_W-1:0]    weight_index;
    logic [WVAL_W-1:0]    weight_value;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
  } in_word_t;

  typedef struct packed {
    logic [WVAL_W-1:0] cell_value;
    logic              out_of_range;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic div_en;
    logic rem_en;
    logic mul_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [LVL_W-1:0] n_levels;
    logic             out_busy;
  } sts_t;

  function automatic logic [CB_W-1:0] clamp_base(input logic [CFG_W-1:0] b);
    logic [CB_W-1:0] r;
    if (b == '0) begin
      r = CB_W'(1);
    end else if (int'(b) > MAX_BASE) begin
      r = CB_W'(MAX_BASE);
    end else begin
      r = CB_W'(b);
    end
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] clamp_levels(input logic [CFG_W-1:0] n);
    logic [LVL_W-1:0] r;
    if (n == '0) begin
      r = LVL_W'(1);
    end else if (int'(n) > MAX_LEVELS) begin
      r = LVL_W'(MAX_LEVELS);
    end else begin
      r = LVL_W'(n);
    end
    return r;
  endfunction

endpackage

### src/mcc_ram.sv
module mcc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/mcc_ctrl.sv
module mcc_ctrl
  import mcc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    lvl_d      = lvl_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // a weight write finishes in the accept cycle
        if (in_valid_i && in_op_i == OP_QUERY) begin
          cmd_o.load = 1'b1;
          lvl_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem_en = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (lvl_q + LVL_W'(1) == sts_i.n_levels) begin
          state_d = ST_FIN;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = ST_DIV;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### src/mcc_dp.sv
module mcc_dp
  import mcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 wr_en_i,
  input  in_word_t             in_data_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o
);

  localparam longint unsigned RecipNum = 64'd1 << RECIP_SHIFT;

  logic [CFG_W-1:0] base_x_q, base_y_q, levels_q;
  logic [CB_W-1:0]  bx, by;

  logic [COORD_W-1:0] row_q, col_q, qrow_q, qcol_q;
  logic [VAL_W-1:0]   acc_q;
  logic               rd_vld_q;
  logic               vld_q [TABLE_DEPTH];
  logic               out_valid_q;
  out_word_t          out_q;

  logic [RECIP_W-1:0] recip_tbl [1:MAX_BASE];

  for (genvar gb = 1; gb <= MAX_BASE; gb++) begin : g_recip
    localparam longint unsigned Den = gb;
    assign recip_tbl[gb] = RECIP_W'((RecipNum + Den - 64'd1) / Den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= CFG_W'(2);
      base_y_q <= CFG_W'(2);
      levels_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BASE_X) begin
        base_x_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_BASE_Y) begin
        base_y_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_LEVELS) begin
        levels_q <= cfg_wdata_i;
      end
    end
  end

  assign bx = clamp_base(base_x_q);
  assign by = clamp_base(base_y_q);
  assign sts_o.n_levels = clamp_levels(levels_q);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // weight writes, saturated to one
  logic                wr_ok;
  logic [ADDR_W-1:0]   wr_addr;
  logic [VAL_W-1:0]    wr_val;

  assign wr_ok   = wr_en_i && (int'(in_data_i.weight_index) < TABLE_DEPTH);
  assign wr_addr = ADDR_W'(in_data_i.weight_index);
  assign wr_val  = (in_data_i.weight_value > WVAL_W'(ONE_FX)) ? ONE_FX
                                                              : VAL_W'(in_data_i.weight_value);

  // divide step: quotient by reciprocal multiply
  logic [COORD_W+RECIP_W-1:0] prod_x, prod_y;
  assign prod_x = {{RECIP_W{1'b0}}, row_q} * {{COORD_W{1'b0}}, recip_tbl[bx]};
  assign prod_y = {{RECIP_W{1'b0}}, col_q} * {{COORD_W{1'b0}}, recip_tbl[by]};

  // remainder step: digits and table slot
  logic [COORD_W+CB_W-1:0] qb_x, qb_y;
  logic [COORD_W-1:0]      rem_x, rem_y;
  logic [DIG_W-1:0]        xd, yd;
  logic [SLOT_W-1:0]       slot_full;
  logic [ADDR_W-1:0]       slot;

  assign qb_x      = {{CB_W{1'b0}}, qrow_q} * {{COORD_W{1'b0}}, bx};
  assign qb_y      = {{CB_W{1'b0}}, qcol_q} * {{COORD_W{1'b0}}, by};
  assign rem_x     = row_q - qb_x[COORD_W-1:0];
  assign rem_y     = col_q - qb_y[COORD_W-1:0];
  assign xd        = rem_x[DIG_W-1:0];
  assign yd        = rem_y[DIG_W-1:0];
  assign slot_full = SLOT_W'(xd) * SLOT_W'(by) + SLOT_W'(yd);
  assign slot      = ADDR_W'(slot_full);

  logic [VAL_W-1:0] rdata;

  mcc_ram #(
    .Width(VAL_W),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_ok),
    .waddr_i(wr_addr),
    .wdata_i(wr_val),
    .re_i   (cmd_i.rem_en),
    .raddr_i(slot),
    .rdata_o(rdata)
  );

  // never-written slots read as zero
  logic [VAL_W-1:0]   weight;
  logic [2*VAL_W-1:0] prod_acc;
  assign weight   = rd_vld_q ? rdata : '0;
  assign prod_acc = {{VAL_W{1'b0}}, acc_q} * {{VAL_W{1'b0}}, weight};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= in_data_i.row;
      col_q <= in_data_i.col;
      acc_q <= ONE_FX;
    end
    if (cmd_i.div_en) begin
      qrow_q <= prod_x[RECIP_SHIFT +: COORD_W];
      qcol_q <= prod_y[RECIP_SHIFT +: COORD_W];
    end
    if (cmd_i.rem_en) begin
      row_q    <= qrow_q;
      col_q    <= qcol_q;
      rd_vld_q <= vld_q[slot];
    end
    if (cmd_i.mul_en) begin
      acc_q <= prod_acc[FRAC_BITS +: VAL_W];
    end
    if (cmd_i.out_load) begin
      // anything left after all levels means the coordinate was outside the grid
      if (row_q == '0 && col_q == '0) begin
        out_q.cell_value   <= WVAL_W'(acc_q);
        out_q.out_of_range <= 1'b0;
      end else begin
        out_q.cell_value   <= '0;
        out_q.out_of_range <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/multinomial_cascade_cell_top.sv
// Channel | Dir | Handshake              | Word
// --------+-----+------------------------+--------------------------------------
// in      | in  | in_valid_i/in_ready_o  | in_data_i (in_word_t)
// out     | out | out_valid_o/out_ready_i| out_data_o (out_word_t)
// cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A weight write completes in its accept cycle. A query runs one shared
// divide / digit / multiply-accumulate step sequence per level, between accept
// and result load. The weight table is a 64-entry RAM with registered read;
// per-entry valid bits make unwritten slots read as zero. Reset is
// asynchronous, active low, and needs no clearing pass. A query waits in its
// last state while the output register still holds an untaken word.
module multinomial_cascade_cell_top
  import mcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic wr_en;

  assign wr_en      = in_valid_i && in_ready && (in_data_i.operation == OP_WRITE);
  assign in_ready_o = in_ready;

  mcc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (in_data_i.operation),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mcc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .wr_en_i    (wr_en),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
